>>> sv/tmpg_pkg.sv
`default_nettype none
package tmpg_pkg;

   localparam int ROWS     = 28;
   localparam int COLS     = 84;
   localparam int SCREEN_W = 640;
   localparam int SCREEN_H = 480;
   localparam int ZOOM     = 2;

   localparam int LEFT_X = 16;
   localparam int TOP_Y  = 22;
   localparam int CELL_W = 6 * ZOOM;
   localparam int CELL_H = 8 * ZOOM;
   localparam int CELLS  = ROWS * COLS;

   localparam int X_W    = 10;
   localparam int Y_W    = 9;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int REM_W  = $clog2(CELL_H);

   // reciprocal scaling for division by the cell and zoom sizes
   localparam int RSH = 20;
   localparam logic [RSH:0] RECIP_W = (RSH+1)'(((1 << RSH) + CELL_W - 1) / CELL_W);
   localparam logic [RSH:0] RECIP_H = (RSH+1)'(((1 << RSH) + CELL_H - 1) / CELL_H);
   localparam logic [RSH:0] RECIP_Z = (RSH+1)'(((1 << RSH) + ZOOM - 1) / ZOOM);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [7:0] COL_TOP_BAR    = 8'h68;
   localparam logic [7:0] COL_BOTTOM_BAR = 8'h05;
   localparam logic [7:0] COL_BODY       = 8'h20;
   localparam logic [7:0] COL_LIT        = 8'hff;

   // glyph line n sits in byte n, line 7 blank
   typedef logic [7:0][7:0] glyph_type;

   localparam glyph_type ALPHA_ROM [26] = '{
      64'h00_11_11_11_1f_11_11_0e, 64'h00_1e_11_11_1e_11_11_1e,
      64'h00_0e_11_10_10_10_11_0e, 64'h00_1e_11_11_11_11_11_1e,
      64'h00_1f_10_10_1e_10_10_1f, 64'h00_10_10_10_1e_10_10_1f,
      64'h00_0f_11_11_17_10_11_0e, 64'h00_11_11_11_1f_11_11_11,
      64'h00_0e_04_04_04_04_04_0e, 64'h00_0c_12_12_02_02_02_07,
      64'h00_11_12_14_18_14_12_11, 64'h00_1f_10_10_10_10_10_10,
      64'h00_11_11_11_15_15_1b_11, 64'h00_11_11_11_13_15_19_11,
      64'h00_0e_11_11_11_11_11_0e, 64'h00_10_10_10_1e_11_11_1e,
      64'h00_0d_12_15_11_11_11_0e, 64'h00_11_12_14_1e_11_11_1e,
      64'h00_1e_01_01_0e_10_10_0f, 64'h00_04_04_04_04_04_04_1f,
      64'h00_0e_11_11_11_11_11_11, 64'h00_04_0a_11_11_11_11_11,
      64'h00_11_1b_15_15_11_11_11, 64'h00_11_11_0a_04_0a_11_11,
      64'h00_04_04_04_04_0a_11_11, 64'h00_1f_10_08_04_02_01_1f
   };

   localparam glyph_type DIGIT_ROM [10] = '{
      64'h00_0e_11_19_15_13_11_0e, 64'h00_0e_04_04_04_04_0c_04,
      64'h00_1f_08_04_02_01_11_0e, 64'h00_1e_01_01_0e_01_01_1e,
      64'h00_02_02_1f_12_0a_06_02, 64'h00_1e_01_01_1e_10_10_1f,
      64'h00_0e_11_11_1e_10_08_06, 64'h00_08_08_08_04_02_01_1f,
      64'h00_0e_11_11_0e_11_11_0e, 64'h00_0c_02_01_0f_11_11_0e
   };

   function automatic glyph_type glyph_lookup(input logic [7:0] code);
      logic [7:0] c;
      logic [7:0] ai;
      logic [7:0] di;
      glyph_type g;
      c = code;
      if (c >= 8'h61 && c <= 8'h7a) begin
         c = c - 8'h20;
      end
      ai = c - 8'h41;
      di = c - 8'h30;
      if (c >= 8'h41 && c <= 8'h5a) begin
         g = ALPHA_ROM[ai[4:0]];
      end else if (c >= 8'h30 && c <= 8'h39) begin
         g = DIGIT_ROM[di[3:0]];
      end else begin
         unique case (c)
            8'h20:   g = 64'h00_00_00_00_00_00_00_00;
            8'h3a:   g = 64'h00_00_04_04_00_04_04_00;
            8'h2d:   g = 64'h00_00_00_00_1f_00_00_00;
            8'h2e:   g = 64'h00_0c_0c_00_00_00_00_00;
            8'h2f:   g = 64'h00_10_08_08_04_02_02_01;
            8'h3d:   g = 64'h00_00_00_1f_00_1f_00_00;
            8'h2b:   g = 64'h00_00_04_04_1f_04_04_00;
            8'h25:   g = 64'h00_03_13_08_04_02_19_18;
            default: g = 64'h00_04_00_04_02_05_11_1f;
         endcase
      end
      return g;
   endfunction

endpackage
`default_nettype wire

>>> sv/text_mode_pixel_generator_unit.sv
// Throughput: one transaction per cycle unless the output stalls on rsp_ready.
// Five register stages (1-4 and the output), each with its own valid bit, and the
// character and row-end memories are read in stage four.
// Reset (synchronous): clears the pipeline and rows_shown, then a clearing pass
// resets every row of the row-end memory; no transaction is accepted meanwhile.
`default_nettype none
module text_mode_pixel_generator_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_op,
   input  wire logic [4:0]                 req_row,
   input  wire logic [6:0]                 req_col,
   input  wire logic [7:0]                 req_code,
   input  wire logic [9:0]                 req_x,
   input  wire logic [8:0]                 req_y,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_pixel,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [4:0]                 csr_data
);
   import tmpg_pkg::*;

   logic [4:0] rows_shown_ff;
   logic       clearing_ff;
   logic [ROW_W-1:0] clr_cnt_ff;

   logic en1, en2, en3, en4, en5;

   // stage 1
   logic             s1_valid_ff, s1_op_ff, s1_skip_ff, s1_wr_ok_ff;
   logic [4:0]       s1_row_ff;
   logic [6:0]       s1_col_ff;
   logic [7:0]       s1_code_ff, s1_bg_ff;
   logic [X_W-1:0]   s1_dx_ff;
   logic [Y_W-1:0]   s1_dy_ff;
   logic [X_W-1:0]   dx_in;
   logic [Y_W-1:0]   dy_in;
   logic             skip_in, wr_ok_in;
   logic [7:0]       bg_in;

   // stage 2
   logic             s2_valid_ff, s2_op_ff, s2_skip_ff, s2_wr_ok_ff;
   logic [Y_W-1:0]   s2_trow_ff, s2_dy_ff;
   logic [X_W-1:0]   s2_cell_ff, s2_dx_ff;
   logic [ADDR_W-1:0] s2_base_ff;
   logic [4:0]       s2_row_ff;
   logic [6:0]       s2_col_ff;
   logic [7:0]       s2_code_ff, s2_bg_ff;
   logic [Y_W+RSH:0] trow_prod;
   logic [X_W+RSH:0] cell_prod;
   logic [ADDR_W-1:0] base_in;

   // stage 3
   logic             s3_valid_ff, s3_op_ff, s3_skip_ff, s3_wr_ok_ff, s3_wzero_ff;
   logic [ADDR_W-1:0] s3_raddr_ff, s3_waddr_ff;
   logic [ROW_W-1:0] s3_mrow_ff, s3_wrow_ff;
   logic [COL_W-1:0] s3_wcol_ff;
   logic [X_W-1:0]   s3_cell_ff;
   logic [REM_W-1:0] s3_grrem_ff, s3_subrem_ff;
   logic [7:0]       s3_code_ff, s3_bg_ff;
   logic [REM_W-1:0] grrem_in, subrem_in;
   logic [ADDR_W-1:0] raddr_in;
   logic             skip3_in;

   // stage 4
   logic             s4_valid_ff, s4_op_ff, s4_skip_ff;
   logic [2:0]       s4_gr_ff, s4_sub_ff;
   logic [X_W-1:0]   s4_cell_ff;
   logic [7:0]       s4_bg_ff;
   logic [7:0]       char_rd_ff;
   logic [COLS-1:0]  mask_rd_ff;
   logic [REM_W+RSH:0] gr_prod, sub_prod;
   logic [2:0]       gr_in, sub_in;
   logic             mem_wr;

   // stage 5
   logic             rsp_valid_ff;
   logic [7:0]       rsp_pixel_ff;
   glyph_type        glyph;
   logic [7:0]       line;
   logic [2:0]       bit_idx;
   logic             zero_hit, lit;
   logic [7:0]       pixel_in;

   logic [7:0]       char_mem [CELLS];
   logic [COLS-1:0]  mask_mem [ROWS];

   assign en5 = !rsp_valid_ff || rsp_ready;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_ready = en1 && !clearing_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_shown_ff <= '0;
         clearing_ff   <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            rows_shown_ff <= csr_data;
         end
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ROW_W'(ROWS - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (en1) s1_valid_ff <= req_valid && req_ready;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
         if (en5) rsp_valid_ff <= s4_valid_ff && (s4_op_ff == OP_PIXEL);
      end
   end

   // stage 1: offsets, screen bounds and background
   always_comb begin
      dx_in    = req_x - X_W'(LEFT_X);
      dy_in    = req_y - Y_W'(TOP_Y);
      skip_in  = (32'(req_y) < TOP_Y) || (32'(req_x) < LEFT_X) || (32'(req_x) >= SCREEN_W);
      wr_ok_in = (32'(req_row) < ROWS) && (32'(req_col) < COLS);
      if (req_y < 9'd12) begin
         bg_in = COL_TOP_BAR;
      end else if (32'(req_y) >= SCREEN_H - 10) begin
         bg_in = COL_BOTTOM_BAR;
      end else begin
         bg_in = COL_BODY;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_op_ff    <= req_op;
         s1_row_ff   <= req_row;
         s1_col_ff   <= req_col;
         s1_code_ff  <= req_code;
         s1_dx_ff    <= dx_in;
         s1_dy_ff    <= dy_in;
         s1_skip_ff  <= skip_in;
         s1_bg_ff    <= bg_in;
         s1_wr_ok_ff <= wr_ok_in;
      end
   end

   // stage 2: text row and cell
   assign trow_prod = (Y_W+RSH+1)'(s1_dy_ff) * (Y_W+RSH+1)'(RECIP_H);
   assign cell_prod = (X_W+RSH+1)'(s1_dx_ff) * (X_W+RSH+1)'(RECIP_W);
   assign base_in   = ADDR_W'(32'(s1_row_ff) * COLS);

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_op_ff    <= s1_op_ff;
         s2_trow_ff  <= trow_prod[RSH +: Y_W];
         s2_cell_ff  <= cell_prod[RSH +: X_W];
         s2_dx_ff    <= s1_dx_ff;
         s2_dy_ff    <= s1_dy_ff;
         s2_skip_ff  <= s1_skip_ff;
         s2_bg_ff    <= s1_bg_ff;
         s2_base_ff  <= base_in;
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_code_ff  <= s1_code_ff;
         s2_wr_ok_ff <= s1_wr_ok_ff;
      end
   end

   // stage 3: remainders, cell address, visibility
   always_comb begin
      grrem_in  = REM_W'(s2_dy_ff - Y_W'(32'(s2_trow_ff) * CELL_H));
      subrem_in = REM_W'(s2_dx_ff - X_W'(32'(s2_cell_ff) * CELL_W));
      raddr_in  = ADDR_W'(32'(s2_trow_ff) * COLS + 32'(s2_cell_ff));
      skip3_in  = s2_skip_ff || (s2_trow_ff >= Y_W'(rows_shown_ff))
                  || (32'(s2_trow_ff) >= ROWS) || (32'(s2_cell_ff) >= COLS);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_op_ff     <= s2_op_ff;
         s3_raddr_ff  <= raddr_in;
         s3_mrow_ff   <= ROW_W'(s2_trow_ff);
         s3_cell_ff   <= s2_cell_ff;
         s3_grrem_ff  <= grrem_in;
         s3_subrem_ff <= subrem_in;
         s3_skip_ff   <= skip3_in;
         s3_bg_ff     <= s2_bg_ff;
         s3_waddr_ff  <= s2_base_ff + ADDR_W'(s2_col_ff);
         s3_wrow_ff   <= ROW_W'(s2_row_ff);
         s3_wcol_ff   <= COL_W'(s2_col_ff);
         s3_code_ff   <= s2_code_ff;
         s3_wzero_ff  <= (s2_code_ff == 8'h00);
         s3_wr_ok_ff  <= s2_wr_ok_ff;
      end
   end

   // stage 4: memory access, glyph line and column
   assign gr_prod  = (REM_W+RSH+1)'(s3_grrem_ff) * (REM_W+RSH+1)'(RECIP_Z);
   assign sub_prod = (REM_W+RSH+1)'(s3_subrem_ff) * (REM_W+RSH+1)'(RECIP_Z);
   assign gr_in    = gr_prod[RSH +: 3];
   assign sub_in   = sub_prod[RSH +: 3];
   assign mem_wr   = en4 && s3_valid_ff && (s3_op_ff == OP_WRITE) && s3_wr_ok_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         char_rd_ff <= char_mem[s3_raddr_ff];
         mask_rd_ff <= mask_mem[s3_mrow_ff];
      end
      if (mem_wr) begin
         char_mem[s3_waddr_ff] <= s3_code_ff;
      end
      if (clearing_ff) begin
         mask_mem[clr_cnt_ff] <= '1;
      end else if (mem_wr) begin
         mask_mem[s3_wrow_ff][s3_wcol_ff] <= s3_wzero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_op_ff   <= s3_op_ff;
         s4_gr_ff   <= gr_in;
         s4_sub_ff  <= sub_in;
         s4_cell_ff <= s3_cell_ff;
         s4_bg_ff   <= s3_bg_ff;
         s4_skip_ff <= s3_skip_ff || (gr_in >= 3'd7) || (sub_in >= 3'd5);
      end
   end

   // stage 5: row end and glyph bit
   always_comb begin
      zero_hit = 1'b0;
      for (int k = 0; k < COLS; k++) begin
         if (mask_rd_ff[k] && (X_W'(k) <= s4_cell_ff)) begin
            zero_hit = 1'b1;
         end
      end
      glyph   = glyph_lookup(char_rd_ff);
      line    = glyph[s4_gr_ff];
      bit_idx = 3'd4 - s4_sub_ff;
      lit     = line[bit_idx];
      if (!s4_skip_ff && !zero_hit && lit) begin
         pixel_in = COL_LIT;
      end else begin
         pixel_in = s4_bg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         rsp_pixel_ff <= pixel_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/tmpg_checker.sv
`default_nettype none
module tmpg_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_pixel,
   input wire logic       csr_ready
);

   // no transaction taken while the row-end memory is cleared
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("transaction accepted during clearing pass");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result present after reset");

   // input held off with an empty output only while clearing, when the pipe is empty
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (!req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("result without pixel transaction");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel)))
      else $error("stalled result changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> csr_ready)
      else $error("register port not ready");

endmodule

bind text_mode_pixel_generator_unit tmpg_checker u_tmpg_checker (.*);
`default_nettype wire
